/* sv/postfix_expression_evaluator_core_assert.svh */
// Assertion macros for the postfix expression evaluator core.
// Depends on nothing; the top level includes it by bare file name.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_CORE_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, reset disables the check
`define PEC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, reset disables the check
`define PEC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PEC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PEC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* sv/pfe_pkg.sv */
// Shared types and constants for the postfix expression evaluator.
// Depends on nothing; used by every module of the block.
package pfe_pkg;

	localparam int DATA_W      = 32;
	localparam int CH_W        = 8;
	localparam int STACK_DEPTH = 64;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W       = $clog2(STACK_DEPTH);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int DIV_CNT_W   = $clog2(DATA_W);

	localparam logic [CH_W-1:0] CH_ADD  = 8'd43;
	localparam logic [CH_W-1:0] CH_SUB  = 8'd45;
	localparam logic [CH_W-1:0] CH_MUL  = 8'd42;
	localparam logic [CH_W-1:0] CH_DIV  = 8'd47;
	localparam logic [CH_W-1:0] CH_ZERO = 8'd48;

	typedef enum logic [2:0] {
		OP_PUSH,
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	// one classified character, as it waits in the queue
	typedef struct packed {
		op_t               op;
		logic [DATA_W-1:0] imm;
		logic              end_mark;
	} cmd_t;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic             busy;
		logic [CNT_W-1:0] count;
	} back_stat_t;

	typedef struct packed {
		logic [DATA_W-1:0] top_value;
		logic              stack_empty;
		logic              underflow;
		logic              overflow;
		logic              div_by_zero;
		logic              final_res;
	} res_t;

endpackage

/* sv/pfe_front.sv */
// Front end: accepts characters and classifies them into stack commands.
// Depends on pfe_pkg; feeds pfe_queue.
module pfe_front (
	input  logic                            char_valid,
	output logic                            char_ready,
	input  logic [pfe_pkg::CH_W-1:0]        ch,
	input  logic                            end_mark,
	input  logic                            q_full,
	output logic                            q_wr,
	output pfe_pkg::cmd_t                   q_cmd
);

	pfe_pkg::op_t op;

	always_comb begin
		unique case (ch)
			pfe_pkg::CH_ADD: op = pfe_pkg::OP_ADD;
			pfe_pkg::CH_SUB: op = pfe_pkg::OP_SUB;
			pfe_pkg::CH_MUL: op = pfe_pkg::OP_MUL;
			pfe_pkg::CH_DIV: op = pfe_pkg::OP_DIV;
			default:         op = pfe_pkg::OP_PUSH;
		endcase
	end

	assign char_ready     = !q_full;
	assign q_wr           = char_valid && !q_full;
	assign q_cmd.op       = op;
	// any other character pushes its code minus the zero digit
	assign q_cmd.imm      = {{(pfe_pkg::DATA_W - pfe_pkg::CH_W){1'b0}}, ch}
	                        - pfe_pkg::DATA_W'(pfe_pkg::CH_ZERO);
	assign q_cmd.end_mark = end_mark;

endmodule

/* sv/pfe_queue.sv */
// Short command queue between the front and back ends.
// Depends on pfe_pkg for the command type and depth.
module pfe_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  pfe_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          pop,
	output logic          rd_valid,
	output pfe_pkg::cmd_t rd_cmd
);

	pfe_pkg::cmd_t                entry_q [pfe_pkg::QUEUE_DEPTH];
	logic [pfe_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [pfe_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [pfe_pkg::QCNT_W-1:0]   fill_q;

	assign full     = fill_q == pfe_pkg::QCNT_W'(pfe_pkg::QUEUE_DEPTH);
	assign rd_valid = fill_q != '0;
	assign rd_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == pfe_pkg::QPTR_W'(pfe_pkg::QUEUE_DEPTH - 1))
				            ? '0 : wr_ptr_q + pfe_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == pfe_pkg::QPTR_W'(pfe_pkg::QUEUE_DEPTH - 1))
				            ? '0 : rd_ptr_q + pfe_pkg::QPTR_W'(1);
			end
			if (wr && !pop) begin
				fill_q <= fill_q + pfe_pkg::QCNT_W'(1);
			end else if (!wr && pop) begin
				fill_q <= fill_q - pfe_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

/* sv/pfe_divider.sv */
// Signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
// Depends on pfe_pkg; serves pfe_back.
module pfe_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  pfe_pkg::div_req_t req,
	output pfe_pkg::div_rsp_t rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic                          neg_q;
	logic [pfe_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [pfe_pkg::DATA_W-1:0]    quo_q;
	logic [pfe_pkg::DATA_W-1:0]    rem_q;
	logic [pfe_pkg::DATA_W-1:0]    dsr_q;
	logic [pfe_pkg::DATA_W:0]      trial;
	logic [pfe_pkg::DATA_W:0]      diff;

	assign trial = {rem_q, quo_q[pfe_pkg::DATA_W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? ('0 - quo_q) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				// work on magnitudes, fix the sign at the end
				neg_q  <= req.dividend[pfe_pkg::DATA_W-1] ^ req.divisor[pfe_pkg::DATA_W-1];
				quo_q  <= req.dividend[pfe_pkg::DATA_W-1] ? ('0 - req.dividend) : req.dividend;
				dsr_q  <= req.divisor[pfe_pkg::DATA_W-1] ? ('0 - req.divisor) : req.divisor;
				rem_q  <= '0;
				cnt_q  <= pfe_pkg::DIV_CNT_W'(pfe_pkg::DATA_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (!diff[pfe_pkg::DATA_W]) begin
					rem_q <= diff[pfe_pkg::DATA_W-1:0];
					quo_q <= {quo_q[pfe_pkg::DATA_W-2:0], 1'b1};
				end else begin
					rem_q <= trial[pfe_pkg::DATA_W-1:0];
					quo_q <= {quo_q[pfe_pkg::DATA_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - pfe_pkg::DIV_CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

/* sv/pfe_back.sv */
// Back end: stack engine with top-of-stack register, entry memory and ALU.
// Depends on pfe_pkg and pfe_divider; drains pfe_queue.
module pfe_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  pfe_pkg::cmd_t       q_cmd,
	output logic                q_pop,
	output logic                res_valid,
	input  logic                res_ready,
	output pfe_pkg::res_t       res,
	output pfe_pkg::back_stat_t stat
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OPND,
		ST_EXEC,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                      state_q;
	pfe_pkg::op_t                op_q;
	logic                        fin_q;
	logic                        under_q;
	logic                        dz_q;
	logic                        res_valid_q;
	pfe_pkg::res_t               res_q;
	logic [pfe_pkg::CNT_W-1:0]   count_q;
	logic [pfe_pkg::DATA_W-1:0]  top_q;
	logic [pfe_pkg::DATA_W-1:0]  lhs_q;
	logic [pfe_pkg::DATA_W-1:0]  rhs_q;
	logic [pfe_pkg::DATA_W-1:0]  arith_q;
	logic [pfe_pkg::DATA_W-1:0]  rd_q;
	logic [pfe_pkg::DATA_W-1:0]  stack_mem [pfe_pkg::STACK_DEPTH];

	logic                        take;
	logic                        is_push;
	logic                        full;
	logic                        two_up;
	logic                        mem_we;
	logic                        mem_re;
	logic [pfe_pkg::CNT_W-1:0]   cnt_dec1;
	logic [pfe_pkg::CNT_W-1:0]   cnt_dec2;
	logic [2*pfe_pkg::DATA_W-1:0] product;
	pfe_pkg::div_req_t           div_req;
	pfe_pkg::div_rsp_t           div_rsp;

	assign take     = (state_q == ST_IDLE) && q_valid && (!res_valid_q || res_ready);
	assign is_push  = q_cmd.op == pfe_pkg::OP_PUSH;
	assign full     = count_q == pfe_pkg::CNT_W'(pfe_pkg::STACK_DEPTH);
	assign two_up   = count_q >= pfe_pkg::CNT_W'(2);
	assign cnt_dec1 = count_q - pfe_pkg::CNT_W'(1);
	assign cnt_dec2 = count_q - pfe_pkg::CNT_W'(2);
	// spill the old top below the new one; fetch the second entry for an operator
	assign mem_we   = take && is_push && !full && (count_q != '0);
	assign mem_re   = take && !is_push && two_up;
	assign product  = lhs_q * rhs_q;

	assign q_pop     = take;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign stat.busy  = state_q != ST_IDLE;
	assign stat.count = count_q;

	assign div_req.start    = (state_q == ST_EXEC) && (op_q == pfe_pkg::OP_DIV)
	                          && (rhs_q != '0);
	assign div_req.dividend = lhs_q;
	assign div_req.divisor  = rhs_q;

	pfe_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[cnt_dec1[pfe_pkg::IDX_W-1:0]] <= top_q;
		end
		if (mem_re) begin
			rd_q <= stack_mem[cnt_dec2[pfe_pkg::IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= pfe_pkg::OP_PUSH;
			fin_q       <= 1'b0;
			under_q     <= 1'b0;
			dz_q        <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
			count_q     <= '0;
			top_q       <= '0;
			lhs_q       <= '0;
			rhs_q       <= '0;
			arith_q     <= '0;
		end else begin
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						op_q  <= q_cmd.op;
						fin_q <= q_cmd.end_mark;
						dz_q  <= 1'b0;
						if (is_push) begin
							// a push finishes here; drop it when the stack is full
							res_valid_q       <= 1'b1;
							res_q.stack_empty <= 1'b0;
							res_q.underflow   <= 1'b0;
							res_q.overflow    <= full;
							res_q.div_by_zero <= 1'b0;
							res_q.final_res   <= q_cmd.end_mark;
							if (full) begin
								res_q.top_value <= top_q;
							end else begin
								res_q.top_value <= q_cmd.imm;
								top_q           <= q_cmd.imm;
								count_q         <= count_q + pfe_pkg::CNT_W'(1);
							end
						end else begin
							rhs_q   <= (count_q != '0) ? top_q : '0;
							under_q <= !two_up;
							if (two_up) begin
								state_q <= ST_OPND;
							end else begin
								lhs_q   <= '0;
								state_q <= ST_EXEC;
							end
						end
					end
				end
				ST_OPND: begin
					lhs_q   <= rd_q;
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_DONE;
					unique case (op_q)
						pfe_pkg::OP_ADD: arith_q <= lhs_q + rhs_q;
						pfe_pkg::OP_SUB: arith_q <= lhs_q - rhs_q;
						pfe_pkg::OP_MUL: arith_q <= product[pfe_pkg::DATA_W-1:0];
						pfe_pkg::OP_DIV: begin
							if (rhs_q == '0) begin
								arith_q <= '0;
								dz_q    <= 1'b1;
							end else begin
								state_q <= ST_DIV;
							end
						end
						default: arith_q <= '0;
					endcase
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						arith_q <= div_rsp.quotient;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// two pops and one push: net one down, or a single entry after underflow
					top_q             <= arith_q;
					count_q           <= two_up ? cnt_dec1 : pfe_pkg::CNT_W'(1);
					res_valid_q       <= 1'b1;
					res_q.top_value   <= arith_q;
					res_q.stack_empty <= 1'b0;
					res_q.underflow   <= under_q;
					res_q.overflow    <= 1'b0;
					res_q.div_by_zero <= dz_q;
					res_q.final_res   <= fin_q;
					state_q           <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* sv/postfix_expression_evaluator_core.sv */
// Postfix expression evaluator core: front end, command queue, stack engine.
// A character passes the queue to the back end. A push finishes in the idle state;
// an operator runs through operand fetch (skipped on underflow), execute and done,
// with a division waiting on the divider. One push per cycle while results are taken.
// Reset (arst_n low): stack and queue empty, no result pending, no clearing pass.
// Depends on pfe_pkg, pfe_front, pfe_queue, pfe_back and the assertion header.
`include "postfix_expression_evaluator_core_assert.svh"

module postfix_expression_evaluator_core (
	input  logic                             clk,
	input  logic                             arst_n,
	// character channel
	input  logic                             char_valid,
	output logic                             char_ready,
	input  logic [pfe_pkg::CH_W-1:0]         ch,
	input  logic                             end_mark,
	// result channel
	output logic                             res_valid,
	input  logic                             res_ready,
	output logic signed [pfe_pkg::DATA_W-1:0] top_value,
	output logic                             stack_empty,
	output logic                             underflow,
	output logic                             overflow,
	output logic                             div_by_zero,
	output logic                             final_res
);

	// Front to queue: classified commands. The queue lets the front take up to
	// two characters while the back end is deep in a division or while a
	// finished result waits in the output register.
	logic                q_wr;
	logic                q_full;
	pfe_pkg::cmd_t       q_wr_cmd;

	// Queue to back end.
	logic                q_valid;
	logic                q_pop;
	pfe_pkg::cmd_t       q_rd_cmd;

	// Back end result register and status.
	pfe_pkg::res_t       res;
	pfe_pkg::back_stat_t stat;

	pfe_front u_front (
		.char_valid (char_valid),
		.char_ready (char_ready),
		.ch         (ch),
		.end_mark   (end_mark),
		.q_full     (q_full),
		.q_wr       (q_wr),
		.q_cmd      (q_wr_cmd)
	);

	pfe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_wr),
		.wr_cmd   (q_wr_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_cmd   (q_rd_cmd)
	);

	// The back end takes a command only once the output register is free
	// (or is being emptied this cycle), so each command owns the result slot
	// until its transaction completes.
	pfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_rd_cmd),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.stat      (stat)
	);

	// Break the result register out onto the ports.
	assign top_value   = res.top_value;
	assign stack_empty = res.stack_empty;
	assign underflow   = res.underflow;
	assign overflow    = res.overflow;
	assign div_by_zero = res.div_by_zero;
	assign final_res   = res.final_res;

	// Overflow comes only from a push; underflow and division by zero only from an operator.
	`PEC_ASSERT_IMP(a_flag_excl, clk, arst_n, res_valid && overflow, !underflow && !div_by_zero, "overflow raised together with an operator flag")
	// Every transaction leaves at least one entry on the stack.
	`PEC_ASSERT_IMP(a_nonempty, clk, arst_n, res_valid, !stack_empty && (stat.count != '0), "stack empty after a step")
	// The entry count never passes the stack depth.
	`PEC_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, stat.count <= pfe_pkg::CNT_W'(pfe_pkg::STACK_DEPTH), "entry count beyond stack depth")
	// While an operator is in flight the result slot stays empty.
	`PEC_ASSERT_IMP(a_busy_slot, clk, arst_n, stat.busy, !res_valid, "result pending while an operator runs")
	// With nothing queued or running, a taken result is not shown again.
	`PEC_ASSERT_NXT(a_no_repeat, clk, arst_n, res_valid && res_ready && !stat.busy && !q_valid, !res_valid, "result repeated")

endmodule

/* sim/pfe_result_checker.sv */
// Result checker for the postfix expression evaluator core: predicts each result
// from the character transactions and compares the result transactions field by field.
// Depends on pfe_pkg.
module pfe_result_checker
	import pfe_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     char_valid,
	input  logic                     char_ready,
	input  logic [CH_W-1:0]          ch,
	input  logic                     end_mark,
	input  logic                     res_valid,
	input  logic                     res_ready,
	input  logic signed [DATA_W-1:0] top_value,
	input  logic                     stack_empty,
	input  logic                     underflow,
	input  logic                     overflow,
	input  logic                     div_by_zero,
	input  logic                     final_res,
	output int                       errors,
	output int                       outstanding
);

	logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
	int                depth = 0;
	res_t              expected_q [$];
	int                fail_cnt = 0;
	int                in_flight = 0;

	assign errors      = fail_cnt;
	assign outstanding = in_flight;

	// an empty stack yields zero and flags the underflow
	function automatic logic [DATA_W-1:0] pop_entry(output logic was_empty);
		was_empty = (depth == 0);
		if (was_empty)
			return '0;
		depth--;
		return stack_mem[depth];
	endfunction

	function automatic res_t predict_char(logic [CH_W-1:0] c, logic last);
		res_t              r;
		logic [DATA_W-1:0] lhs, rhs, val, mag_l, mag_r, quo;
		logic              empty_r, empty_l;
		r = '0;
		if (c == CH_ADD || c == CH_SUB || c == CH_MUL || c == CH_DIV) begin
			rhs = pop_entry(empty_r);
			lhs = pop_entry(empty_l);
			r.underflow = empty_r | empty_l;
			case (c)
				CH_ADD: val = lhs + rhs;
				CH_SUB: val = lhs - rhs;
				CH_MUL: val = lhs * rhs;
				default: begin
					if (rhs == '0) begin
						val = '0;
						r.div_by_zero = 1'b1;
					end else begin
						// divide magnitudes, then restore the sign; MIN / -1 wraps
						mag_l = lhs[DATA_W-1] ? -lhs : lhs;
						mag_r = rhs[DATA_W-1] ? -rhs : rhs;
						quo   = mag_l / mag_r;
						val   = (lhs[DATA_W-1] ^ rhs[DATA_W-1]) ? -quo : quo;
					end
				end
			endcase
		end else begin
			val = DATA_W'(c) - DATA_W'(CH_ZERO);
		end
		if (depth < STACK_DEPTH) begin
			stack_mem[depth] = val;
			depth++;
		end else begin
			r.overflow = 1'b1;
		end
		r.stack_empty = (depth == 0);
		r.top_value   = (depth == 0) ? '0 : stack_mem[depth-1];
		r.final_res   = last;
		return r;
	endfunction

	function automatic int field_mismatch(string name, logic [DATA_W-1:0] want,
			logic [DATA_W-1:0] got);
		if (got === want)
			return 0;
		$display("%0t mismatch on %s: expected %h, actual %h", $time, name, want, got);
		return 1;
	endfunction

	always @(posedge clk) begin
		res_t got, want;
		int   bad;
		bad = 0;
		if (arst_n) begin
			// compare before predicting, so a premature result cannot hide
			if (res_valid && res_ready) begin
				got = {top_value, stack_empty, underflow, overflow, div_by_zero, final_res};
				if (expected_q.size() == 0) begin
					$display("%0t unexpected result: expected none, actual %h", $time, got);
					bad++;
				end else begin
					want = expected_q.pop_front();
					bad += field_mismatch("top_value", want.top_value, got.top_value);
					bad += field_mismatch("stack_empty", want.stack_empty, got.stack_empty);
					bad += field_mismatch("underflow", want.underflow, got.underflow);
					bad += field_mismatch("overflow", want.overflow, got.overflow);
					bad += field_mismatch("div_by_zero", want.div_by_zero, got.div_by_zero);
					bad += field_mismatch("final_res", want.final_res, got.final_res);
				end
			end
			if (char_valid && char_ready)
				expected_q.push_back(predict_char(ch, end_mark));
			fail_cnt  <= fail_cnt + bad;
			in_flight <= expected_q.size();
		end
	end

endmodule

/* sim/tb_postfix_expression_evaluator_core.sv */
// Testbench top for the postfix expression evaluator core: drives character
// transactions and random result back-pressure, and gives the verdict.
// Depends on pfe_pkg, the core and pfe_result_checker.
module tb_postfix_expression_evaluator_core;
	import pfe_pkg::*;

	localparam int ITEM_TARGET  = 1300;
	localparam int CYCLE_LIMIT  = 1_000_000;
	// allow for a division to finish, with slack to spare
	localparam int DRAIN_CYCLES = 80;
	// pushes 128, a handy building block for large powers of two
	localparam logic [CH_W-1:0] CH_POW7 = CH_ZERO + 8'd128;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     char_valid = 1'b0;
	logic                     char_ready;
	logic [CH_W-1:0]          ch = '0;
	logic                     end_mark = 1'b0;
	logic                     res_valid;
	logic                     res_ready = 1'b0;
	logic signed [DATA_W-1:0] top_value;
	logic                     stack_empty;
	logic                     underflow;
	logic                     overflow;
	logic                     div_by_zero;
	logic                     final_res;
	int                       errors;
	int                       outstanding;

	int sent = 0;
	int src_calm = 0;
	int sink_calm = 0;
	int sink_stall = 0;
	int cycles = 0;

	postfix_expression_evaluator_core uut (.*);

	pfe_result_checker result_check (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	// Gap lengths: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Operand: mostly a decimal digit, otherwise any non-operator code.
	function automatic logic [CH_W-1:0] pick_operand();
		logic [CH_W-1:0] c;
		if ($urandom_range(0, 3) != 0)
			return CH_ZERO + CH_W'($urandom_range(0, 9));
		do
			c = CH_W'($urandom_range(0, 255));
		while (c == CH_ADD || c == CH_SUB || c == CH_MUL || c == CH_DIV);
		return c;
	endfunction

	// Operator: keep division rarer, since it costs the divider's full latency.
	function automatic logic [CH_W-1:0] pick_operator();
		case ($urandom_range(0, 6))
			0, 1: return CH_ADD;
			2, 3: return CH_SUB;
			4, 5: return CH_MUL;
			default: return CH_DIV;
		endcase
	endfunction

	// Present one character transaction and hold it until it is taken.
	task automatic send_char(input logic [CH_W-1:0] c, input logic last);
		int gap;
		if (src_calm > 0) begin
			src_calm--;
			gap = 0;
		end else begin
			gap = pick_gap();
			// occasionally run back to back for a while
			if ($urandom_range(0, 79) == 0)
				src_calm = $urandom_range(30, 120);
		end
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_valid <= 1'b1;
		ch         <= c;
		end_mark   <= last;
		do
			@(posedge clk);
		while (!char_ready);
		sent++;
	endtask

	// Well-formed postfix expression: every operator finds two operands
	// from this expression, and the last character carries the end mark.
	task automatic send_expression();
		int operands, pushed, level;
		operands = $urandom_range(1, 7);
		pushed   = 0;
		level    = 0;
		while (pushed < operands || level > 1) begin
			if (pushed < operands && (level < 2 || $urandom_range(0, 1) == 0)) begin
				send_char(pick_operand(), pushed + 1 == operands && level == 0);
				pushed++;
				level++;
			end else begin
				send_char(pick_operator(), pushed == operands && level == 2);
				level--;
			end
		end
	endtask

	// Result side: random stalls, with stretches of constant readiness.
	always @(posedge clk) begin
		if (arst_n) begin
			if (sink_calm > 0) begin
				sink_calm--;
				res_ready <= 1'b1;
			end else if (sink_stall > 0) begin
				sink_stall--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
				if ($urandom_range(0, 99) == 0)
					sink_calm = $urandom_range(40, 200);
				else
					sink_stall = pick_gap();
			end
		end
	end

	// Watchdog: abandon the run if it hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int pick;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Operators on a short stack: the division finds it empty, so both pops underflow
		// and 0 / 0 also flags division by zero; the addition then underflows on one pop.
		send_char(CH_DIV, 1'b0);
		send_char(CH_ADD, 1'b1);
		// Extreme codes: 0 pushes -48, 255 pushes 207.
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(CH_SUB, 1'b1);
		// Division by zero with a non-zero dividend.
		send_char(CH_ZERO + 8'd9, 1'b0);
		send_char(CH_ZERO, 1'b0);
		send_char(CH_DIV, 1'b1);
		// Build the most negative value by wrapping multiplication
		// (128^4 * 8 = 2^31), then divide it by -1.
		send_char(CH_POW7, 1'b0);
		send_char(CH_POW7, 1'b0);
		send_char(CH_MUL, 1'b0);
		send_char(CH_POW7, 1'b0);
		send_char(CH_MUL, 1'b0);
		send_char(CH_POW7, 1'b0);
		send_char(CH_MUL, 1'b0);
		send_char(CH_ZERO + 8'd8, 1'b0);
		send_char(CH_MUL, 1'b0);
		send_char(CH_ZERO, 1'b0);
		send_char(CH_ZERO + 8'd1, 1'b0);
		send_char(CH_SUB, 1'b0);
		send_char(CH_DIV, 1'b1);
		// Truncation toward zero: -7 / 2 gives -3.
		send_char(CH_ZERO, 1'b0);
		send_char(CH_ZERO + 8'd7, 1'b0);
		send_char(CH_SUB, 1'b0);
		send_char(CH_ZERO + 8'd2, 1'b0);
		send_char(CH_DIV, 1'b1);

		// Random part: mostly well-formed expressions; operator runs drain
		// the stack into underflow, push runs fill it into overflow, and
		// noise covers every code and end mark.
		while (sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				send_expression();
			else if (pick < 80)
				repeat ($urandom_range(1, 70)) send_char(pick_operator(), 1'b0);
			else if (pick < 90)
				repeat ($urandom_range(1, 70)) send_char(pick_operand(), 1'b0);
			else
				repeat ($urandom_range(1, 8))
					send_char(CH_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end
		char_valid <= 1'b0;

		// Let the checker count the last transaction, then drain results.
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
